// ===== src/pdvl_pkg.sv =====
// shared types and constants for the pd velocity limiter
`timescale 1ns / 1ps
package pdvl_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned GainW  = 16;
  localparam int unsigned LimW   = 24;
  localparam int unsigned VelW   = 25;
  localparam int unsigned TermW  = 43;
  localparam int unsigned RemW   = 45;
  localparam int unsigned ErrMagW = 33;
  localparam int unsigned CntW   = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned NumAxes = 3;

  localparam logic [CfgIdxW-1:0] CfgKp       = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKd       = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSpeedLim = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgArrTol   = 2'd3;

  localparam logic [CntW-1:0] DivLastBit = 5'd23;

  typedef struct packed {
    logic tgt_we;
    logic pos_we;
    logic err_en;
    logic mul_en;
    logic sum_en;
    logic div_init;
    logic div_step;
    logic lim_bit;
  } lane_ctrl_t;

  typedef struct packed {
    logic [TermW-1:0] largest;
    logic             over;
    logic             arrived;
  } merge_res_t;

endpackage

// ===== src/pdvl_if.sv =====
// request and result channel interfaces
`timescale 1ns / 1ps
interface pdvl_in_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic signed [pdvl_pkg::PosW-1:0] pos_x;
  logic signed [pdvl_pkg::PosW-1:0] pos_y;
  logic signed [pdvl_pkg::PosW-1:0] pos_z;
  modport source(output valid, cmd, pos_x, pos_y, pos_z, input ready);
  modport sink(input valid, cmd, pos_x, pos_y, pos_z, output ready);
endinterface

interface pdvl_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [pdvl_pkg::VelW-1:0] vel_x;
  logic signed [pdvl_pkg::VelW-1:0] vel_y;
  logic signed [pdvl_pkg::VelW-1:0] vel_z;
  logic                             arrived;
  modport source(output valid, vel_x, vel_y, vel_z, arrived, input ready);
  modport sink(input valid, vel_x, vel_y, vel_z, arrived, output ready);
endinterface

// ===== src/pdvl_lane.sv =====
// one axis: error, pd term and shift-subtract scaling
`timescale 1ns / 1ps
module pdvl_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pdvl_pkg::lane_ctrl_t                ctrl_i,
  input  logic signed [pdvl_pkg::PosW-1:0]    pos_i,
  input  logic [pdvl_pkg::GainW-1:0]          kp_i,
  input  logic [pdvl_pkg::GainW-1:0]          kd_i,
  input  logic [pdvl_pkg::TermW-1:0]          div_m_i,
  output logic                                tgt_match_o,
  output logic [pdvl_pkg::TermW-1:0]          mag_o,
  output logic [pdvl_pkg::ErrMagW-1:0]        err_mag_o,
  output logic                                neg_o,
  output logic signed [pdvl_pkg::TermW-1:0]   term_o,
  output logic [pdvl_pkg::LimW-1:0]           quo_o
);
  localparam int unsigned PW = pdvl_pkg::PosW;
  localparam int unsigned TW = pdvl_pkg::TermW;
  localparam int unsigned RW = pdvl_pkg::RemW;
  localparam int unsigned ErrMagW = pdvl_pkg::ErrMagW;

  logic signed [PW-1:0]   tgt_q, pos_q, last_q, e_q;
  logic signed [PW:0]     d_q;
  logic signed [PW+16:0]  pp_q;
  logic signed [PW+17:0]  pd_q;
  logic signed [TW-1:0]   term_q;
  logic [TW-1:0]          mag_q;
  logic [RW-1:0]          r_q;
  logic [pdvl_pkg::LimW-1:0] q_q;

  logic signed [PW:0]     diff;
  logic signed [PW-1:0]   e_d;
  logic signed [PW+18:0]  acc;
  logic signed [PW+18:0]  acc_sh;
  logic [RW-1:0]          r1, r2, r_d;
  logic [pdvl_pkg::LimW-1:0] q_d;
  logic [RW-1:0]          m_ext, a_ext;

  always_comb begin
    diff = {tgt_q[PW-1], tgt_q} - {pos_q[PW-1], pos_q};
    if (diff[PW] != diff[PW-1]) begin
      e_d = diff[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    end else begin
      e_d = diff[PW-1:0];
    end
    acc    = {{2{pp_q[PW+16]}}, pp_q} + {pd_q[PW+17], pd_q};
    acc_sh = acc >>> 8;
    m_ext  = {{(RW-TW){1'b0}}, div_m_i};
    a_ext  = {{(RW-TW){1'b0}}, mag_q};
    r1     = {r_q[RW-2:0], 1'b0};
    q_d    = {q_q[pdvl_pkg::LimW-2:0], 1'b0};
    if (r1 >= m_ext) begin
      r1  = r1 - m_ext;
      q_d = q_d + 1'b1;
    end
    r2 = r1;
    if (ctrl_i.lim_bit) begin
      r2 = r1 + a_ext;
      if (r2 >= m_ext) begin
        r2  = r2 - m_ext;
        q_d = q_d + 1'b1;
      end
    end
    r_d = r2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q  <= '0;
      last_q <= '0;
    end else begin
      if (ctrl_i.tgt_we) begin
        tgt_q <= pos_i;
      end
      if (ctrl_i.err_en) begin
        last_q <= e_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pos_we) begin
      pos_q <= pos_i;
    end
    if (ctrl_i.err_en) begin
      e_q <= e_d;
      d_q <= {e_d[PW-1], e_d} - {last_q[PW-1], last_q};
    end
    if (ctrl_i.mul_en) begin
      pp_q <= e_q * $signed({1'b0, kp_i});
      pd_q <= d_q * $signed({1'b0, kd_i});
    end
    if (ctrl_i.sum_en) begin
      term_q <= acc_sh[TW-1:0];
      mag_q  <= acc_sh[PW+18] ? TW'(-acc_sh[TW-1:0]) : acc_sh[TW-1:0];
    end
    if (ctrl_i.div_init) begin
      r_q <= '0;
      q_q <= '0;
    end else if (ctrl_i.div_step) begin
      r_q <= r_d;
      q_q <= q_d;
    end
  end

  assign tgt_match_o = (pos_i == tgt_q);
  assign mag_o       = mag_q;
  assign err_mag_o   = e_q[PW-1] ? ErrMagW'(-{e_q[PW-1], e_q}) : {1'b0, e_q};
  assign neg_o       = term_q[TW-1];
  assign term_o      = term_q;
  assign quo_o       = q_q;
endmodule

// ===== src/pdvl_merge.sv =====
// combines lane magnitudes into largest term, limit flag and arrived
`timescale 1ns / 1ps
module pdvl_merge (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [pdvl_pkg::TermW-1:0]        mag_i [pdvl_pkg::NumAxes],
  input  logic [pdvl_pkg::ErrMagW-1:0]      err_mag_i [pdvl_pkg::NumAxes],
  input  logic [pdvl_pkg::LimW-1:0]         speed_limit_i,
  input  logic [pdvl_pkg::LimW-1:0]         tol_i,
  output pdvl_pkg::merge_res_t              res_o
);
  pdvl_pkg::merge_res_t res_q, res_d;
  logic [pdvl_pkg::TermW-1:0] m01;

  always_comb begin
    m01           = (mag_i[1] > mag_i[0]) ? mag_i[1] : mag_i[0];
    res_d.largest = (mag_i[2] > m01) ? mag_i[2] : m01;
    res_d.over    = res_d.largest >
                    {{(pdvl_pkg::TermW-pdvl_pkg::LimW){1'b0}}, speed_limit_i};
    res_d.arrived = 1'b1;
    for (int i = 0; i < pdvl_pkg::NumAxes; i++) begin
      if (err_mag_i[i] > {{(pdvl_pkg::ErrMagW-pdvl_pkg::LimW){1'b0}}, tol_i}) begin
        res_d.arrived = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;
endmodule

// ===== src/three_axis_pd_velocity_limiter_unit.sv =====
// top level of the three-axis pd velocity limiter
`timescale 1ns / 1ps
// A target request (cmd 0) is absorbed while idle and gives no result. A measured
// request (cmd 1) with a target held runs three axis lanes in parallel: error,
// multiply, sum, merge of the magnitudes, then a shift-subtract scaling when the
// largest term exceeds speed_limit. The result sits in an output register, so
// the next request is taken while it waits.
module three_axis_pd_velocity_limiter_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  pdvl_in_if.sink                           req_i,
  pdvl_out_if.source                        rsp_o,
  input  logic                              cfg_we_i,
  input  logic [pdvl_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [pdvl_pkg::LimW-1:0]         cfg_data_i
);
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_ERR  = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_SUM  = 7'b0001000,
    ST_MAX  = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  localparam int unsigned VW = pdvl_pkg::VelW;

  state_e state_q, state_d;
  logic [pdvl_pkg::GainW-1:0] kp_q, kd_q;
  logic [pdvl_pkg::LimW-1:0]  lim_q, tol_q;
  logic                       tgt_valid_q;
  logic [pdvl_pkg::CntW-1:0]  cnt_q;
  logic                       out_valid_q, out_arr_q;
  logic signed [VW-1:0]       out_vel_q [pdvl_pkg::NumAxes];

  pdvl_pkg::lane_ctrl_t       ctrl;
  pdvl_pkg::merge_res_t       mres;
  logic                       acc_in, same_tgt, out_load;
  logic                       match [pdvl_pkg::NumAxes];
  logic [pdvl_pkg::TermW-1:0] mag [pdvl_pkg::NumAxes];
  logic [pdvl_pkg::ErrMagW-1:0] emag [pdvl_pkg::NumAxes];
  logic                       neg [pdvl_pkg::NumAxes];
  logic signed [pdvl_pkg::TermW-1:0] term [pdvl_pkg::NumAxes];
  logic [pdvl_pkg::LimW-1:0]  quo [pdvl_pkg::NumAxes];
  logic signed [pdvl_pkg::PosW-1:0] pos [pdvl_pkg::NumAxes];
  logic signed [VW-1:0]       vel [pdvl_pkg::NumAxes];

  assign pos[0] = req_i.pos_x;
  assign pos[1] = req_i.pos_y;
  assign pos[2] = req_i.pos_z;

  assign req_i.ready = (state_q == ST_IDLE);
  assign acc_in      = req_i.valid && req_i.ready;
  assign same_tgt    = tgt_valid_q && match[0] && match[1] && match[2];
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    ctrl          = '0;
    ctrl.tgt_we   = acc_in && !req_i.cmd && !same_tgt;
    ctrl.pos_we   = acc_in && req_i.cmd && tgt_valid_q;
    ctrl.err_en   = (state_q == ST_ERR);
    ctrl.mul_en   = (state_q == ST_MUL);
    ctrl.sum_en   = (state_q == ST_SUM);
    ctrl.div_init = (state_q == ST_MAX);
    ctrl.div_step = (state_q == ST_DIV) && mres.over;
    ctrl.lim_bit  = lim_q[cnt_q];
    state_d       = state_q;
    unique case (state_q)
      ST_IDLE: if (ctrl.pos_we) state_d = ST_ERR;
      ST_ERR:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_MAX;
      ST_MAX:  state_d = ST_DIV;
      ST_DIV:  if (!mres.over || cnt_q == '0) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  for (genvar g = 0; g < pdvl_pkg::NumAxes; g++) begin : g_lane
    pdvl_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .pos_i       (pos[g]),
      .kp_i        (kp_q),
      .kd_i        (kd_q),
      .div_m_i     (mres.largest),
      .tgt_match_o (match[g]),
      .mag_o       (mag[g]),
      .err_mag_o   (emag[g]),
      .neg_o       (neg[g]),
      .term_o      (term[g]),
      .quo_o       (quo[g])
    );
    assign vel[g] = !mres.over ? term[g][VW-1:0] :
                    (neg[g] ? -$signed({1'b0, quo[g]}) : $signed({1'b0, quo[g]}));
  end

  pdvl_merge u_merge (
    .clk_i         (clk_i),
    .en_i          (ctrl.sum_en || (state_q == ST_MAX) ? (state_q == ST_MAX) : 1'b0),
    .mag_i         (mag),
    .err_mag_i     (emag),
    .speed_limit_i (lim_q),
    .tol_i         (tol_q),
    .res_o         (mres)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kp_q        <= 16'd256;
      kd_q        <= 16'd3840;
      lim_q       <= 24'd327680;
      tol_q       <= 24'd32768;
      tgt_valid_q <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pdvl_pkg::CfgKp:       kp_q  <= cfg_data_i[pdvl_pkg::GainW-1:0];
          pdvl_pkg::CfgKd:       kd_q  <= cfg_data_i[pdvl_pkg::GainW-1:0];
          pdvl_pkg::CfgSpeedLim: lim_q <= cfg_data_i;
          pdvl_pkg::CfgArrTol:   tol_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ctrl.tgt_we) begin
        tgt_valid_q <= 1'b1;
      end
      if (state_q == ST_MAX) begin
        cnt_q <= pdvl_pkg::DivLastBit;
      end else if (ctrl.div_step && cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_vel_q <= vel;
      out_arr_q <= mres.arrived;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.vel_x   = out_vel_q[0];
  assign rsp_o.vel_y   = out_vel_q[1];
  assign rsp_o.vel_z   = out_vel_q[2];
  assign rsp_o.arrived = out_arr_q;
endmodule
